[rtl/keypad_debounce_repeat_fifo_assert.svh]
// Assertion macros for the keypad qualifier checker
`ifndef KEYPAD_DEBOUNCE_REPEAT_FIFO_ASSERT_SVH
`define KEYPAD_DEBOUNCE_REPEAT_FIFO_ASSERT_SVH

// same-cycle implication, quiet during reset
`define KDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define KDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/kdr_pkg.sv]
// Shared types, constants and helpers for the keypad qualifier
package kdr_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int MATRIX_W  = 9;
  localparam int KEY_W     = 4;
  localparam int CODE_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_OFFSET = 2'd2;

  localparam logic [CODE_W-1:0] STABLE_TICKS_RST  = 8'd4;
  localparam logic [CODE_W-1:0] REPEAT_TICKS_RST  = 8'd50;
  localparam logic [CODE_W-1:0] REPEAT_OFFSET_RST = 8'd16;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] stable_ticks;
    logic [CODE_W-1:0] repeat_ticks;
    logic [CODE_W-1:0] repeat_offset;
  } cfg_t;

  // pushes asked for by one tick: press code first, repeat code second
  typedef struct packed {
    logic              press;
    logic              repeat_push;
    logic [CODE_W-1:0] press_code;
    logic [CODE_W-1:0] repeat_code;
  } push_req_t;

  typedef struct packed {
    logic has_key;
    logic dropped;
  } fifo_status_t;

  // lowest-numbered pressed key, 1..9, or 0 for none
  function automatic logic [KEY_W-1:0] key_of(input logic [MATRIX_W-1:0] m);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int i = MATRIX_W - 1; i >= 0; i--) begin
      if (m[i]) k = KEY_W'(i + 1);
    end
    return k;
  endfunction

endpackage

[rtl/keypad_debounce_repeat_fifo.sv]
// Pipeline: an accepted word is held in stage s1, then in the result register at out_valid.
// Throughput: one word per cycle while out_stall is low; a tick that queues both a press
//   and a repeat code holds the input while the queue's write port is busy.
// Reset (rst, synchronous): control state and pointers clear, registers take their
//   defaults; queue storage is not cleared, entries are read only after written.
module keypad_debounce_repeat_fifo #(
  parameter int QUEUE_DEPTH = kdr_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [kdr_pkg::MATRIX_W-1:0]  key_matrix,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          has_key,
  output logic [kdr_pkg::CODE_W-1:0]    key_code,
  output logic [CNT_W-1:0]              queue_level,
  output logic                          dropped,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kdr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kdr_pkg::CODE_W-1:0]    cfg_data
);

  kdr_pkg::cfg_t cfg;

  logic                         s1_valid;
  logic                         s1_req;
  logic [kdr_pkg::MATRIX_W-1:0] s1_matrix;

  logic             res_valid;
  logic             res_has_key;
  logic             res_dropped;
  logic [CNT_W-1:0] res_level;

  logic                       advance, accept, busy;
  kdr_pkg::push_req_t         push;
  kdr_pkg::fifo_status_t      status;
  logic [CNT_W-1:0]           level_next;
  logic [kdr_pkg::CODE_W-1:0] rd_data;

  assign advance  = s1_valid && !busy && (!res_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_ticks  <= kdr_pkg::STABLE_TICKS_RST;
      cfg.repeat_ticks  <= kdr_pkg::REPEAT_TICKS_RST;
      cfg.repeat_offset <= kdr_pkg::REPEAT_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kdr_pkg::CFG_STABLE_TICKS:  cfg.stable_ticks  <= cfg_data;
        kdr_pkg::CFG_REPEAT_TICKS:  cfg.repeat_ticks  <= cfg_data;
        kdr_pkg::CFG_REPEAT_OFFSET: cfg.repeat_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req    <= req_type;
      s1_matrix <= key_matrix;
    end
  end

  kdr_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .tick       (advance && (s1_req == kdr_pkg::REQ_TICK)),
    .key_matrix (s1_matrix),
    .cfg        (cfg),
    .push       (push)
  );

  kdr_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .req_type   (s1_req),
    .push       (push),
    .status     (status),
    .level_next (level_next),
    .rd_data    (rd_data),
    .busy       (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_has_key <= status.has_key;
      res_dropped <= status.dropped;
      res_level   <= level_next;
    end
  end

  assign out_valid   = res_valid;
  assign has_key     = res_has_key;
  assign key_code    = res_has_key ? rd_data : '0;
  assign queue_level = res_level;
  assign dropped     = res_dropped;

endmodule

[rtl/kdr_scan.sv]
// Key encoder, debounce counter and auto-repeat decision
module kdr_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  logic [kdr_pkg::MATRIX_W-1:0] key_matrix,
  input  kdr_pkg::cfg_t               cfg,
  output kdr_pkg::push_req_t          push
);

  logic [kdr_pkg::KEY_W-1:0]  last_code, last_code_next;
  logic [kdr_pkg::CODE_W-1:0] hold_count, hold_count_next;
  logic [kdr_pkg::KEY_W-1:0]  code;
  logic                       same;
  logic                       at_repeat;

  always_comb begin
    code       = kdr_pkg::key_of(key_matrix);
    same       = (code != '0) && (code == last_code);
    at_repeat  = hold_count >= cfg.repeat_ticks;

    push.press       = same && (hold_count == cfg.stable_ticks);
    push.repeat_push = same && at_repeat;
    push.press_code  = kdr_pkg::CODE_W'(code);
    push.repeat_code = kdr_pkg::CODE_W'(code) + cfg.repeat_offset;

    last_code_next  = last_code;
    hold_count_next = hold_count;
    if (code == '0) begin
      last_code_next  = '0;
      hold_count_next = '0;
    end else if (same) begin
      // count stops at the repeat threshold, so it never wraps
      if (!at_repeat) hold_count_next = hold_count + 1'b1;
    end else begin
      last_code_next  = code;
      hold_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_code  <= '0;
      hold_count <= '0;
    end else if (tick) begin
      last_code  <= last_code_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

[rtl/kdr_fifo.sv]
// Ring queue of key codes with a single write port
module kdr_fifo #(
  parameter int QUEUE_DEPTH = kdr_pkg::QUEUE_DEPTH_DEF,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       req_type,
  input  kdr_pkg::push_req_t         push,
  output kdr_pkg::fifo_status_t      status,
  output logic [CNT_W-1:0]           level_next,
  output logic [kdr_pkg::CODE_W-1:0] rd_data,
  output logic                       busy
);

  logic [kdr_pkg::CODE_W-1:0] key_queue [QUEUE_DEPTH];

  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_after_press;

  logic                       pend;
  logic [PTR_W-1:0]           pend_addr;
  logic [kdr_pkg::CODE_W-1:0] pend_data;

  logic                       is_read, pop_ok, press_ok, repeat_ok, both_ok;
  logic [PTR_W-1:0]           wp_plus1;
  logic                       wr_en;
  logic [PTR_W-1:0]           wr_addr;
  logic [kdr_pkg::CODE_W-1:0] wr_data;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    is_read          = (req_type == kdr_pkg::REQ_READ);
    pop_ok           = is_read && (fill_count != '0);
    press_ok         = !is_read && push.press && (fill_count < CNT_W'(QUEUE_DEPTH));
    fill_after_press = fill_count + CNT_W'(press_ok);
    repeat_ok        = !is_read && push.repeat_push &&
                       (fill_after_press < CNT_W'(QUEUE_DEPTH));
    both_ok          = press_ok && repeat_ok;
    wp_plus1         = ptr_inc(write_ptr);

    status.has_key = pop_ok;
    status.dropped = !is_read && ((push.press && !press_ok) ||
                                  (push.repeat_push && !repeat_ok));

    if (pop_ok)
      level_next = fill_count - 1'b1;
    else
      level_next = fill_after_press + CNT_W'(repeat_ok);

    read_ptr_next  = pop_ok ? ptr_inc(read_ptr) : read_ptr;
    write_ptr_next = both_ok ? ptr_inc(wp_plus1) :
                     (press_ok || repeat_ok) ? wp_plus1 : write_ptr;

    // a deferred second code owns the write port while pend is set
    if (pend) begin
      wr_en   = 1'b1;
      wr_addr = pend_addr;
      wr_data = pend_data;
    end else begin
      wr_en   = advance && (press_ok || repeat_ok);
      wr_addr = write_ptr;
      wr_data = press_ok ? push.press_code : push.repeat_code;
    end
  end

  assign busy = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      fill_count <= '0;
      pend       <= 1'b0;
    end else begin
      pend <= advance && both_ok;
      if (advance) begin
        write_ptr  <= write_ptr_next;
        read_ptr   <= read_ptr_next;
        fill_count <= level_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pend_addr <= wp_plus1;
      pend_data <= push.repeat_code;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) key_queue[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (advance && pop_ok) rd_data <= key_queue[read_ptr];
  end

endmodule

[rtl/kdr_checker.sv]
// Port-level checker for the keypad qualifier, bound to the top level
`include "keypad_debounce_repeat_fifo_assert.svh"

module kdr_checker #(
  parameter int QUEUE_DEPTH = kdr_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       has_key,
  input logic [kdr_pkg::CODE_W-1:0] key_code,
  input logic [CNT_W-1:0]           queue_level,
  input logic                       dropped
);

  `KDR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(key_code) && $stable(queue_level) && $stable(has_key) && $stable(dropped), "stalled result word changed")
  `KDR_ASSERT_NOW(a_code_zero, out_valid && !has_key, key_code == '0, "key code without a popped entry")
  `KDR_ASSERT_NOW(a_level_max, out_valid, queue_level <= CNT_W'(QUEUE_DEPTH), "queue level beyond depth")
  `KDR_ASSERT_NOW(a_drop_full, out_valid && dropped, queue_level == CNT_W'(QUEUE_DEPTH) && !has_key, "drop with room left or on a read")

endmodule

bind keypad_debounce_repeat_fifo kdr_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);
